// ===== hdl/ltre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_pkg: shared types and constants of the luma threshold run extractor
// Widths, register indexes and the record types passed between the chunk
// scanner and the top level.
// ----------------------------------------------------------------------------
package ltre_pkg;

    // geometry of one chunk
    localparam int LANES          = 8;
    localparam int LANE_BITS      = 3;
    localparam int LUMA_W         = 8;

    // widths of the stream fields
    localparam int COL_W          = 11;
    localparam int END_W          = 12;
    localparam int ROW_W          = 11;

    // configuration register widths and limits
    localparam int THR_W          = 8;
    localparam int WC_W           = 9;
    localparam int HR_W           = 12;
    localparam int CHUNK_W        = 8;
    localparam int MAX_WC         = 256;
    localparam int MAX_HR         = 2048;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);
    localparam logic [WC_W-1:0]  WC_RESET  = WC_W'(80);
    localparam logic [HR_W-1:0]  HR_RESET  = HR_W'(480);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_CHUNKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS  = 2'd2;

    // results per chunk: four runs closed inside, one more closed at row end
    localparam int MAX_RES        = 5;
    localparam int RES_CNT_W      = 3;

    // stream packing
    localparam int IN_DATA_W      = LANES * LUMA_W;
    localparam int OUT_DATA_W     = 40;
    localparam int OUT_USER_W     = 3;

    // one result held for the output
    typedef struct packed {
        logic             has_run;
        logic [COL_W-1:0] run_start;
        logic [END_W-1:0] run_end;
    } t_run_entry;

    // per-row tracking state carried from chunk to chunk
    typedef struct packed {
        logic               in_run;
        logic [COL_W-1:0]   open_start;
        logic [CHUNK_W-1:0] chunk_col;
        logic [ROW_W-1:0]   row_cnt;
    } t_scan_state;

    // row and frame status of one scanned chunk
    typedef struct packed {
        logic                 row_end;
        logic                 frame_end;
        logic [RES_CNT_W-1:0] count;
    } t_scan_status;

endpackage

// ===== hdl/ltre_chunk_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltre_chunk_scan: threshold and run extraction for one chunk
// Marks each lane above the threshold, walks the lanes left to right and
// lists the runs that close, plus the run or marker at row end.
// ----------------------------------------------------------------------------
module ltre_chunk_scan (
    input  logic [ltre_pkg::IN_DATA_W-1:0]  i_luma,
    input  logic [ltre_pkg::THR_W-1:0]      i_threshold,
    input  logic [ltre_pkg::WC_W-1:0]       i_width_chunks,
    input  logic [ltre_pkg::HR_W-1:0]       i_height_rows,
    input  ltre_pkg::t_scan_state           i_state,
    output ltre_pkg::t_scan_state           o_state,
    output ltre_pkg::t_scan_status          o_status,
    output ltre_pkg::t_run_entry            o_ent [ltre_pkg::MAX_RES]
);

    logic [ltre_pkg::WC_W-1:0]  wc_eff;
    logic [ltre_pkg::HR_W-1:0]  hr_eff;
    logic [ltre_pkg::LANES-1:0] marked;
    logic [ltre_pkg::COL_W-1:0] base;
    logic                       row_end;
    logic                       frame_end;

    // saturate width and height to their legal ranges
    always_comb begin
        wc_eff = i_width_chunks;
        if (i_width_chunks == '0) begin
            wc_eff = ltre_pkg::WC_W'(1);
        end else if (i_width_chunks > ltre_pkg::WC_W'(ltre_pkg::MAX_WC)) begin
            wc_eff = ltre_pkg::WC_W'(ltre_pkg::MAX_WC);
        end
        hr_eff = i_height_rows;
        if (i_height_rows == '0) begin
            hr_eff = ltre_pkg::HR_W'(1);
        end else if (i_height_rows > ltre_pkg::HR_W'(ltre_pkg::MAX_HR)) begin
            hr_eff = ltre_pkg::HR_W'(ltre_pkg::MAX_HR);
        end
    end

    // per-lane threshold compare
    always_comb begin
        for (int i = 0; i < ltre_pkg::LANES; i++) begin
            marked[i] = i_luma[i*ltre_pkg::LUMA_W +: ltre_pkg::LUMA_W] > i_threshold;
        end
    end

    assign base      = ltre_pkg::COL_W'(i_state.chunk_col) << ltre_pkg::LANE_BITS;
    assign row_end   = (ltre_pkg::WC_W'(i_state.chunk_col) + ltre_pkg::WC_W'(1)) >= wc_eff;
    assign frame_end = (ltre_pkg::HR_W'(i_state.row_cnt) + ltre_pkg::HR_W'(1)) >= hr_eff;

    // lane walk: collect closed runs, then close or mark at row end
    always_comb begin
        logic                           cur_in;
        logic [ltre_pkg::COL_W-1:0]     cur_start;
        logic [ltre_pkg::RES_CNT_W-1:0] n;
        logic [ltre_pkg::COL_W-1:0]     here;

        cur_in    = i_state.in_run;
        cur_start = i_state.open_start;
        n         = '0;
        here      = '0;
        for (int k = 0; k < ltre_pkg::MAX_RES; k++) begin
            o_ent[k] = '0;
        end

        for (int i = 0; i < ltre_pkg::LANES; i++) begin
            here = base + ltre_pkg::COL_W'(i);
            if (marked[i] != cur_in) begin
                if (cur_in) begin
                    o_ent[n].has_run   = 1'b1;
                    o_ent[n].run_start = cur_start;
                    o_ent[n].run_end   = ltre_pkg::END_W'(here);
                    n = n + ltre_pkg::RES_CNT_W'(1);
                end else begin
                    cur_start = here;
                end
                cur_in = marked[i];
            end
        end

        if (row_end) begin
            if (cur_in) begin
                o_ent[n].has_run   = 1'b1;
                o_ent[n].run_start = cur_start;
                o_ent[n].run_end   = ltre_pkg::END_W'(wc_eff) << ltre_pkg::LANE_BITS;
                n = n + ltre_pkg::RES_CNT_W'(1);
            end
            // empty row end still reports one marker, already zeroed
            if (n == '0) begin
                n = ltre_pkg::RES_CNT_W'(1);
            end
        end

        o_status.row_end   = row_end;
        o_status.frame_end = row_end && frame_end;
        o_status.count     = n;

        // next tracking state
        if (row_end) begin
            o_state.in_run     = 1'b0;
            o_state.open_start = '0;
            o_state.chunk_col  = '0;
            o_state.row_cnt    = frame_end ? '0
                                 : i_state.row_cnt + ltre_pkg::ROW_W'(1);
        end else begin
            o_state.in_run     = cur_in;
            o_state.open_start = cur_start;
            o_state.chunk_col  = i_state.chunk_col + ltre_pkg::CHUNK_W'(1);
            o_state.row_cnt    = i_state.row_cnt;
        end
    end

endmodule

// ===== hdl/luma_threshold_run_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_threshold_run_extractor: binary threshold run-length encoder
// Turns a raster luma stream into per-row runs of pixels above a threshold.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one chunk of eight luma bytes per transaction, pixel 0 in
//   the lowest byte, rows in raster order. m_axis carries one result per
//   transaction: a run (start, exclusive end) or a row marker; tuser flags
//   has_run, row_done and frame_done, tlast ends the results of one chunk.
//   Every row gives at least one result; the last one carries row_done.
//   Configuration (threshold, width in chunks, height) is written through
//   the plain write port while the stream is idle.
// Timing
//   A chunk's results are registered and appear in the cycle after its
//   transaction. While m_axis is ready, a chunk that gives one result or none
//   does not hold s_axis; one that gives more (at most five) holds it, as the
//   output register bank sends one result per cycle while m_axis is ready.
//   The next chunk is taken in the cycle the last result of the previous one leaves.
// Reset and stall
//   Reset clears the row and column position, the open run and the output
//   bank's valid flag and counters, and restores the default registers.
//   While m_axis stalls, results hold and s_axis tready is low once one waits.
// ----------------------------------------------------------------------------
module luma_threshold_run_extractor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input chunk: luma0 [7:0], luma1 .. luma7 [63:56]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ltre_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // result: run_start [10:0], run_end [22:11], row_index [33:23], zero pad
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ltre_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // result flags: has_run [0], row_done [1], frame_done [2]
    output logic [ltre_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ltre_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ltre_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [ltre_pkg::THR_W-1:0]     r_threshold;
    logic [ltre_pkg::WC_W-1:0]      r_width_chunks;
    logic [ltre_pkg::HR_W-1:0]      r_height_rows;

    ltre_pkg::t_scan_state          r_state;
    ltre_pkg::t_scan_state          n_state;
    ltre_pkg::t_scan_status         scan_status;
    ltre_pkg::t_run_entry           scan_ent [ltre_pkg::MAX_RES];

    ltre_pkg::t_run_entry           r_ent [ltre_pkg::MAX_RES];
    logic                           r_valid;
    logic [ltre_pkg::RES_CNT_W-1:0] r_cnt;
    logic [ltre_pkg::RES_CNT_W-1:0] r_idx;
    logic [ltre_pkg::ROW_W-1:0]     r_row;
    logic                           r_row_done;
    logic                           r_frame_done;

    logic                           in_take;
    logic                           out_take;
    logic                           last_ent;
    ltre_pkg::t_run_entry           cur_ent;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= ltre_pkg::THR_RESET;
            r_width_chunks <= ltre_pkg::WC_RESET;
            r_height_rows  <= ltre_pkg::HR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ltre_pkg::CFG_THRESHOLD:
                    r_threshold    <= i_cfg_data[ltre_pkg::THR_W-1:0];
                ltre_pkg::CFG_WIDTH_CHUNKS:
                    r_width_chunks <= i_cfg_data[ltre_pkg::WC_W-1:0];
                ltre_pkg::CFG_HEIGHT_ROWS:
                    r_height_rows  <= i_cfg_data[ltre_pkg::HR_W-1:0];
                default: ;
            endcase
        end
    end

    // chunk scanner
    ltre_chunk_scan u_scan (
        .i_luma         (s_axis_tdata),
        .i_threshold    (r_threshold),
        .i_width_chunks (r_width_chunks),
        .i_height_rows  (r_height_rows),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_status       (scan_status),
        .o_ent          (scan_ent)
    );

    // handshake
    assign cur_ent       = r_ent[r_idx];
    assign last_ent      = (r_idx == r_cnt - ltre_pkg::RES_CNT_W'(1));
    assign out_take      = r_valid && m_axis_tready;
    assign s_axis_tready = !r_valid || (m_axis_tready && last_ent);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // row tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // output bank control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else if (in_take) begin
            r_valid <= (scan_status.count != '0);
            r_idx   <= '0;
            r_cnt   <= scan_status.count;
        end else if (out_take) begin
            if (last_ent) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + ltre_pkg::RES_CNT_W'(1);
        end
    end

    // output bank payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ent        <= scan_ent;
            r_row        <= r_state.row_cnt;
            r_row_done   <= scan_status.row_end;
            r_frame_done <= scan_status.frame_end;
        end
    end

    // result stream
    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = last_ent;
    assign m_axis_tdata  = ltre_pkg::OUT_DATA_W'({r_row, cur_ent.run_end, cur_ent.run_start});
    assign m_axis_tuser  = {r_frame_done && last_ent, r_row_done && last_ent, cur_ent.has_run};

endmodule
